FILE: hw/rtl/touch_wheel_gesture_tracker_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef TOUCH_WHEEL_GESTURE_TRACKER_MACROS_SVH
`define TOUCH_WHEEL_GESTURE_TRACKER_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define TWGT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define TWGT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle.
`define TWGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/twgt_pkg.sv
package twgt_pkg;

  localparam int AVG_SAMPLES = 4;
  localparam int SLOT_W      = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int MAG_W       = $clog2(AVG_SAMPLES * 128 + 1);
  localparam int TOT_W       = MAG_W + 1;
  localparam int STEP_W      = 9;
  localparam int RECIP_SH    = 16;
  localparam int RECIP_W     = RECIP_SH + 1;
  localparam int RECIP       = ((2 ** RECIP_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_SAMPLES - 1);

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam int IN_W       = 48;
  localparam int OUT_W      = 48;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_NOTIFY     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PEAK_LIMIT = 3'd6;

  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [TOT_W-1:0]  tot_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_TOUCH_DOWN = 3'd1,
    EV_TOUCH_UP   = 3'd2,
    EV_SLIDE      = 3'd3,
    EV_TAP_LEFT   = 3'd4,
    EV_TAP_TOP    = 3'd5,
    EV_TAP_RIGHT  = 3'd6,
    EV_TAP_BOTTOM = 3'd7
  } event_kind_t;

  typedef struct packed {
    logic       notify;
    logic [7:0] left_center;
    logic [7:0] top_center;
    logic [7:0] right_center;
    logic [7:0] bottom_center;
    logic [7:0] half_width;
    logic [7:0] peak_limit;
  } cfg_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [7:0]         position;
    logic signed [7:0]  delta;
    logic [31:0]        duration;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic near_zone(logic [7:0] pos, logic [7:0] center,
                                     logic [7:0] half_width);
    logic signed [8:0] d;
    logic [8:0]        a;
    d = $signed({1'b0, pos}) - $signed({1'b0, center});
    a = d[8] ? 9'(-d) : 9'(d);
    return a < {1'b0, half_width};
  endfunction

endpackage

FILE: hw/rtl/touch_wheel_gesture_tracker.sv
// Channel   Ports                        Payload (low bit first)
// in        in_tvalid/in_tready          change_active, touch_present, wheel_position, now_ms
// out       out_tvalid/out_tready        position, smoothed_delta, duration_ms; kind in tuser
// cfg       cfg_psel/penable/pwrite      7 registers at byte address 4*i
//
// A poll is updated from the input register once the queue has room, and its results are
// written into the queue in that cycle; polls enter one per cycle while the queue has room.
// The output moves one result per cycle while out_tready is high; two results leave in turn.
// Reset is synchronous; a valid bit per ring entry makes the step ring read as zero.
// Once three results wait in the four-entry queue, hold the poll in the input register
// and drop in_tready until out_tready drains the queue.
module touch_wheel_gesture_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // change_active[0], touch_present[1], wheel_position[9:2], now_ms[41:10]
  input  logic [twgt_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // position[7:0], smoothed_delta[15:8], duration_ms[47:16]
  output logic [twgt_pkg::OUT_W-1:0]        out_tdata,
  // event_kind[2:0]
  output logic [2:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [twgt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [twgt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [twgt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import twgt_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space_ok;

  twgt_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  twgt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .space_ok  (space_ok),
    .push      (push)
  );

  twgt_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/twgt_ring_ram.sv
`include "touch_wheel_gesture_tracker_macros.svh"

module twgt_ring_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [twgt_pkg::SLOT_W-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [twgt_pkg::SLOT_W-1:0]   wr_addr,
  input  twgt_pkg::step_t               wr_data,
  output twgt_pkg::step_t               rd_data
);
  import twgt_pkg::*;

  step_t                  mem [AVG_SAMPLES];
  logic [AVG_SAMPLES-1:0] valid_r;
  step_t                  rd_data_r;
  logic                   rd_hit_r;
  logic                   bypass;

  assign bypass  = wr_en && (wr_addr == rd_addr);
  assign rd_data = rd_hit_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= bypass ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_hit_r <= bypass || valid_r[rd_addr];
    end
  end

  `TWGT_ASSERT_NEXT(a_ram_valid_set, wr_en, valid_r[$past(wr_addr)], "ring entry not marked valid")
  `TWGT_ASSERT_NEXT(a_ram_bypass, bypass, rd_hit_r && (rd_data_r == $past(wr_data)), "ring bypass lost")

endmodule

FILE: hw/rtl/twgt_result_fifo.sv
`include "touch_wheel_gesture_tracker_macros.svh"

module twgt_result_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  twgt_pkg::push_t                 push,
  output logic                            space_ok,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [twgt_pkg::OUT_W-1:0]      out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast
);
  import twgt_pkg::*;

  result_t                mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wp_r, wp_nxt;
  logic [RES_PTR_W-1:0]   rp_r, rp_nxt;
  logic [RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   pop;
  result_t                head;

  assign pop        = (cnt_r != '0) && out_tready;
  assign space_ok   = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign head       = mem[rp_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {head.duration, head.delta, head.position};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_comb begin
    wp_nxt  = wp_r + RES_PTR_W'(push.cnt);
    rp_nxt  = rp_r + RES_PTR_W'(pop);
    cnt_nxt = cnt_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `TWGT_ASSERT_ALWAYS(a_fifo_bound, cnt_r <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
  `TWGT_ASSERT_IMPLY(a_fifo_push_room, push.cnt != 2'd0, space_ok, "push without room")

endmodule

FILE: hw/rtl/twgt_cfg_regs.sv
module twgt_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [twgt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [twgt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [twgt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output twgt_pkg::cfg_t                    cfg
);
  import twgt_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.notify        <= 1'b0;
      cfg_r.left_center   <= 8'd140;
      cfg_r.top_center    <= 8'd220;
      cfg_r.right_center  <= 8'd35;
      cfg_r.bottom_center <= 8'd90;
      cfg_r.half_width    <= 8'd10;
      cfg_r.peak_limit    <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_NOTIFY:     cfg_r.notify        <= cfg_pwdata[0];
        REG_LEFT:       cfg_r.left_center   <= cfg_pwdata[7:0];
        REG_TOP:        cfg_r.top_center    <= cfg_pwdata[7:0];
        REG_RIGHT:      cfg_r.right_center  <= cfg_pwdata[7:0];
        REG_BOTTOM:     cfg_r.bottom_center <= cfg_pwdata[7:0];
        REG_HALF_WIDTH: cfg_r.half_width    <= cfg_pwdata[7:0];
        REG_PEAK_LIMIT: cfg_r.peak_limit    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NOTIFY:     cfg_prdata = CFG_DATA_W'(cfg_r.notify);
      REG_LEFT:       cfg_prdata = CFG_DATA_W'(cfg_r.left_center);
      REG_TOP:        cfg_prdata = CFG_DATA_W'(cfg_r.top_center);
      REG_RIGHT:      cfg_prdata = CFG_DATA_W'(cfg_r.right_center);
      REG_BOTTOM:     cfg_prdata = CFG_DATA_W'(cfg_r.bottom_center);
      REG_HALF_WIDTH: cfg_prdata = CFG_DATA_W'(cfg_r.half_width);
      REG_PEAK_LIMIT: cfg_prdata = CFG_DATA_W'(cfg_r.peak_limit);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/twgt_core.sv
`include "touch_wheel_gesture_tracker_macros.svh"

module twgt_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twgt_pkg::cfg_t              cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [twgt_pkg::IN_W-1:0]   in_tdata,
  input  logic                        space_ok,
  output twgt_pkg::push_t             push
);
  import twgt_pkg::*;

  logic                item_v_r;
  logic                chg_r;
  logic                tch_r;
  logic [7:0]          pos_r;
  logic [31:0]         now_r;

  logic                dragging_r, dragging_nxt;
  logic [7:0]          stored_r, stored_nxt;
  logic [31:0]         start_r, start_nxt;
  logic [7:0]          peak_r, peak_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  tot_t                total_r, total_nxt;

  logic                fire;
  logic                ring_we;
  step_t               ring_entry;
  logic signed [9:0]   diff;
  step_t               step;
  tot_t                new_total;
  tot_t                abs_total;
  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          quo;
  logic [7:0]          new_peak;
  logic signed [7:0]   avg;
  logic [SLOT_W-1:0]   slot_inc;
  logic [31:0]         dur;
  event_kind_t         tap_kind;

  assign fire      = item_v_r && space_ok;
  assign in_tready = !item_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      chg_r <= in_tdata[0];
      tch_r <= in_tdata[1];
      pos_r <= in_tdata[9:2];
      now_r <= in_tdata[41:10];
    end
  end

  twgt_ring_ram u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (slot_nxt),
    .wr_en   (ring_we),
    .wr_addr (slot_r),
    .wr_data (step),
    .rd_data (ring_entry)
  );

  always_comb begin
    diff = $signed({2'b00, pos_r}) - $signed({2'b00, stored_r});
    if (diff < -10'sd128) begin
      step = STEP_W'(diff + 10'sd255);
    end else if (diff > 10'sd128) begin
      step = STEP_W'(diff - 10'sd255);
    end else begin
      step = STEP_W'(diff);
    end
    new_total = total_r - tot_t'(ring_entry) + tot_t'(step);
    abs_total = new_total[TOT_W-1] ? -new_total : new_total;
    mag       = abs_total[MAG_W-1:0];
    prod      = PROD_W'(mag) * PROD_W'(RECIP);
    quo       = prod[RECIP_SH +: 8];
    new_peak  = (quo > peak_r) ? quo : peak_r;
    if (new_total[TOT_W-1]) begin
      avg = -$signed(quo);
    end else if (quo[7]) begin
      avg = 8'sd127;
    end else begin
      avg = $signed(quo);
    end
    slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
    dur      = now_r - start_r;
    if (near_zone(stored_r, cfg.left_center, cfg.half_width)) begin
      tap_kind = EV_TAP_LEFT;
    end else if (near_zone(stored_r, cfg.top_center, cfg.half_width)) begin
      tap_kind = EV_TAP_TOP;
    end else if (near_zone(stored_r, cfg.right_center, cfg.half_width)) begin
      tap_kind = EV_TAP_RIGHT;
    end else if (near_zone(stored_r, cfg.bottom_center, cfg.half_width)) begin
      tap_kind = EV_TAP_BOTTOM;
    end else begin
      tap_kind = EV_NONE;
    end
  end

  always_comb begin
    dragging_nxt = dragging_r;
    stored_nxt   = stored_r;
    start_nxt    = start_r;
    peak_nxt     = peak_r;
    slot_nxt     = slot_r;
    total_nxt    = total_r;
    ring_we      = 1'b0;
    push         = '0;
    if (fire) begin
      if (!chg_r || !tch_r) begin
        if (dragging_r) begin
          push.cnt         = 2'd1;
          push.r0.kind     = EV_TOUCH_UP;
          push.r0.position = stored_r;
          push.r0.duration = dur;
          if (peak_r <= cfg.peak_limit && tap_kind != EV_NONE) begin
            push.cnt         = 2'd2;
            push.r1.kind     = tap_kind;
            push.r1.position = stored_r;
            push.r1.duration = dur;
          end
          dragging_nxt = 1'b0;
          peak_nxt     = '0;
        end
        if (!chg_r) begin
          stored_nxt = '0;
        end
      end else if (!dragging_r) begin
        stored_nxt       = pos_r;
        dragging_nxt     = 1'b1;
        start_nxt        = now_r;
        peak_nxt         = '0;
        push.cnt         = 2'd1;
        push.r0.kind     = EV_TOUCH_DOWN;
        push.r0.position = pos_r;
      end else begin
        ring_we          = 1'b1;
        total_nxt        = new_total;
        slot_nxt         = slot_inc;
        stored_nxt       = pos_r;
        peak_nxt         = new_peak;
        push.cnt         = 2'd1;
        push.r0.kind     = (new_peak > cfg.peak_limit) ? EV_SLIDE : EV_TOUCH_DOWN;
        push.r0.position = pos_r;
        push.r0.delta    = avg;
      end
    end
    if (!cfg.notify) begin
      push.cnt = 2'd0;
    end
    if (push.cnt == 2'd1) begin
      push.r0.last = 1'b1;
    end
    if (push.cnt == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dragging_r <= 1'b0;
      stored_r   <= '0;
      start_r    <= '0;
      peak_r     <= '0;
      slot_r     <= '0;
      total_r    <= '0;
    end else begin
      dragging_r <= dragging_nxt;
      stored_r   <= stored_nxt;
      start_r    <= start_nxt;
      peak_r     <= peak_nxt;
      slot_r     <= slot_nxt;
      total_r    <= total_nxt;
    end
  end

  `TWGT_ASSERT_NEXT(a_slot_hold, !ring_we, $stable(slot_r) && $stable(total_r), "ring moved off step")
  `TWGT_ASSERT_IMPLY(a_step_drag, ring_we, fire && dragging_r, "ring write outside a drag")
  `TWGT_ASSERT_ALWAYS(a_peak_range, peak_r <= 8'd128, "peak out of range")

endmodule

FILE: bench/gesture_event_check.sv
module gesture_event_check
  import twgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic [2:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    event_errors,
  output int                    pending
);

  cfg_t                regs;
  logic                dragging;
  logic [7:0]          held_pos;
  logic [31:0]         touch_start;
  logic [7:0]          peak;
  step_t               steps [AVG_SAMPLES];
  logic [SLOT_W-1:0]   slot;
  int                  total;
  int                  errors;
  result_t             events_due [$];
  result_t             fresh [2];
  int                  fresh_n;

  function automatic logic in_zone(logic [7:0] pos, logic [7:0] center);
    int gap;
    gap = int'(pos) - int'(center);
    if (gap < 0) gap = -gap;
    return gap < int'(regs.half_width);
  endfunction

  task automatic add_event(event_kind_t kind, logic [7:0] pos, logic [7:0] delta,
                           logic [31:0] dur);
    fresh[fresh_n].kind     = kind;
    fresh[fresh_n].position = pos;
    fresh[fresh_n].delta    = delta;
    fresh[fresh_n].duration = dur;
    fresh[fresh_n].last     = 1'b0;
    fresh_n++;
  endtask

  task automatic release_touch(logic [31:0] stamp);
    logic [31:0] dur;
    event_kind_t tap;
    if (!dragging) return;
    dur = stamp - touch_start;
    tap = EV_NONE;
    if (regs.notify) begin
      add_event(EV_TOUCH_UP, held_pos, 8'd0, dur);
      if (peak <= regs.peak_limit) begin
        if (in_zone(held_pos, regs.left_center)) tap = EV_TAP_LEFT;
        else if (in_zone(held_pos, regs.top_center)) tap = EV_TAP_TOP;
        else if (in_zone(held_pos, regs.right_center)) tap = EV_TAP_RIGHT;
        else if (in_zone(held_pos, regs.bottom_center)) tap = EV_TAP_BOTTOM;
        if (tap != EV_NONE) add_event(tap, held_pos, 8'd0, dur);
      end
    end
    dragging = 1'b0;
    peak = 8'd0;
  endtask

  task automatic track_poll(logic [IN_W-1:0] poll);
    logic        chg;
    logic        tch;
    logic [7:0]  pos;
    logic [31:0] stamp;
    int          step;
    int          avg;
    int          mag;
    chg = poll[0];
    tch = poll[1];
    pos = poll[9:2];
    stamp = poll[41:10];
    fresh_n = 0;
    if (!chg) begin
      release_touch(stamp);
      held_pos = 8'd0;
    end else if (!tch) begin
      release_touch(stamp);
    end else if (!dragging) begin
      held_pos = pos;
      dragging = 1'b1;
      touch_start = stamp;
      peak = 8'd0;
      if (regs.notify) add_event(EV_TOUCH_DOWN, held_pos, 8'd0, 32'd0);
    end else begin
      step = int'(pos) - int'(held_pos);
      if (step < -128) step += 255;
      if (step > 128) step -= 255;
      total = total - int'(steps[slot]) + step;
      steps[slot] = step_t'(step);
      slot = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      avg = total / AVG_SAMPLES;
      held_pos = pos;
      mag = (avg < 0) ? -avg : avg;
      if (mag > int'(peak)) peak = mag[7:0];
      if (avg > 127) avg = 127;
      if (avg < -128) avg = -128;
      if (regs.notify) begin
        if (peak > regs.peak_limit) add_event(EV_SLIDE, pos, avg[7:0], 32'd0);
        else add_event(EV_TOUCH_DOWN, held_pos, avg[7:0], 32'd0);
      end
    end
    if (fresh_n > 0) fresh[fresh_n-1].last = 1'b1;
    for (int i = 0; i < fresh_n; i++) events_due.push_back(fresh[i]);
  endtask

  task automatic flag(string why, result_t want, result_t got);
    errors++;
    if (errors <= 10)
      $display("%s: want kind=%0d pos=%0d delta=%0d dur=%0d last=%0b, got kind=%0d pos=%0d delta=%0d dur=%0d last=%0b",
               why, want.kind, want.position, $signed(want.delta), want.duration, want.last,
               got.kind, got.position, $signed(got.delta), got.duration, got.last);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      regs.notify = 1'b0;
      regs.left_center = 8'd140;
      regs.top_center = 8'd220;
      regs.right_center = 8'd35;
      regs.bottom_center = 8'd90;
      regs.half_width = 8'd10;
      regs.peak_limit = 8'd1;
      dragging = 1'b0;
      held_pos = 8'd0;
      touch_start = 32'd0;
      peak = 8'd0;
      for (int i = 0; i < AVG_SAMPLES; i++) steps[i] = '0;
      slot = '0;
      total = 0;
      errors = 0;
      events_due.delete();
      event_errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_NOTIFY:     regs.notify = cfg_pwdata[0];
          REG_LEFT:       regs.left_center = cfg_pwdata[7:0];
          REG_TOP:        regs.top_center = cfg_pwdata[7:0];
          REG_RIGHT:      regs.right_center = cfg_pwdata[7:0];
          REG_BOTTOM:     regs.bottom_center = cfg_pwdata[7:0];
          REG_HALF_WIDTH: regs.half_width = cfg_pwdata[7:0];
          REG_PEAK_LIMIT: regs.peak_limit = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.kind = event_kind_t'(out_tuser);
        got.position = out_tdata[7:0];
        got.delta = out_tdata[15:8];
        got.duration = out_tdata[47:16];
        got.last = out_tlast;
        if (events_due.size() == 0) begin
          want = '0;
          flag("unexpected transaction", want, got);
        end else begin
          want = events_due.pop_front();
          if (got.kind !== want.kind || got.position !== want.position ||
              got.delta !== want.delta || got.duration !== want.duration ||
              got.last !== want.last)
            flag("mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) track_poll(in_tdata);
      event_errors <= errors;
      pending <= events_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import twgt_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    event_errors;
  int                    pending;

  int                    polls;
  int                    burst_left;
  logic [31:0]           clock_ms;
  int                    zone_c [4];
  int                    half_w;
  logic [15:0]           stall_pat;
  int                    pat_age;

  touch_wheel_gesture_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gesture_event_check tracker_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .event_errors (event_errors),
    .pending      (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom & $urandom);
        default: stall_pat = 16'($urandom | $urandom);
      endcase
      stall_pat[0] = 1'b1;
    end
    pat_age = pat_age - 1;
    out_tready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic notify, input int l, input int t, input int r,
                            input int b, input int h, input int lim);
    cfg_write(REG_NOTIFY, ($urandom & 32'hFFFF_FFFE) | 32'(notify));
    cfg_write(REG_LEFT, ($urandom & 32'hFFFF_FF00) | 32'(l));
    cfg_write(REG_TOP, ($urandom & 32'hFFFF_FF00) | 32'(t));
    cfg_write(REG_RIGHT, ($urandom & 32'hFFFF_FF00) | 32'(r));
    cfg_write(REG_BOTTOM, ($urandom & 32'hFFFF_FF00) | 32'(b));
    cfg_write(REG_HALF_WIDTH, ($urandom & 32'hFFFF_FF00) | 32'(h));
    cfg_write(REG_PEAK_LIMIT, ($urandom & 32'hFFFF_FF00) | 32'(lim));
    zone_c[0] = l;
    zone_c[1] = t;
    zone_c[2] = r;
    zone_c[3] = b;
    half_w = h;
  endtask

  task automatic poll(input logic chg, input logic tch, input logic [7:0] pos,
                      input logic [31:0] stamp);
    int gap;
    in_tdata <= {6'd0, stamp, pos, tch, chg};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    polls++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic tick();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 400);
  endtask

  task automatic gesture();
    int         mode;
    int         moves;
    int         d;
    logic [7:0] p;
    mode = $urandom_range(0, 9);
    tick();
    if (mode == 0) begin
      poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom), clock_ms);
      return;
    end
    if (mode <= 3)
      p = 8'(zone_c[$urandom_range(0, 3)] + $urandom_range(0, 2 * half_w) - half_w);
    else
      p = 8'($urandom);
    poll(1'b1, 1'b1, p, clock_ms);
    moves = (mode <= 3) ? $urandom_range(0, 4) : $urandom_range(1, 14);
    for (int i = 0; i < moves; i++) begin
      tick();
      if ($urandom_range(0, 14) == 0) begin
        poll(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), clock_ms);
        continue;
      end
      if (mode <= 3) d = $urandom_range(0, 2) - 1;
      else if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 255);
      else d = $urandom_range(0, 24) - 12;
      p = p + 8'(d);
      poll(1'b1, 1'b1, p, clock_ms);
    end
    tick();
    if ($urandom_range(0, 2) == 0)
      poll(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), clock_ms);
    else poll(1'b1, 1'b0, 8'($urandom), clock_ms);
    if ($urandom_range(0, 3) == 0) begin
      tick();
      poll(1'($urandom_range(0, 1)), 1'b0, 8'($urandom), clock_ms);
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    stop_at = polls + count;
    while (polls < stop_at) gesture();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    #(12 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    polls = 0;
    burst_left = 5;
    clock_ms = 32'd100;
    pat_age = 0;
    stall_pat = 16'hFFFF;
    zone_c[0] = 140;
    zone_c[1] = 220;
    zone_c[2] = 35;
    zone_c[3] = 90;
    half_w = 10;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // events off after reset: state moves, nothing reported
    poll(1'b1, 1'b1, 8'd50, 32'd100);
    poll(1'b1, 1'b1, 8'd60, 32'd110);
    poll(1'b1, 1'b0, 8'd0, 32'd120);
    poll(1'b0, 1'b0, 8'd0, 32'd130);
    settle();
    cfg_write(REG_NOTIFY, 32'hFFFF_FFFF);

    poll(1'b0, 1'b0, 8'd0, 32'd0);
    poll(1'b1, 1'b1, 8'd140, 32'd1000);
    poll(1'b1, 1'b1, 8'd140, 32'd1010);
    poll(1'b1, 1'b0, 8'd77, 32'd1050);
    poll(1'b1, 1'b1, 8'd220, 32'd2000);
    poll(1'b0, 1'b1, 8'd9, 32'd2100);
    poll(1'b1, 1'b1, 8'd35, 32'hFFFF_FFF0);
    poll(1'b1, 1'b0, 8'd0, 32'h0000_0010);
    poll(1'b1, 1'b1, 8'd90, 32'd3000);
    poll(1'b1, 1'b1, 8'd91, 32'd3001);
    poll(1'b1, 1'b0, 8'd0, 32'd3002);
    poll(1'b1, 1'b1, 8'd150, 32'd4000);
    poll(1'b1, 1'b0, 8'd0, 32'd4001);
    // wrap the step both ways, then the largest steps
    poll(1'b1, 1'b1, 8'd0, 32'd5000);
    poll(1'b1, 1'b1, 8'd128, 32'd5010);
    poll(1'b1, 1'b1, 8'd0, 32'd5020);
    poll(1'b1, 1'b1, 8'd255, 32'd5030);
    poll(1'b1, 1'b1, 8'd0, 32'd5040);
    poll(1'b1, 1'b1, 8'd250, 32'd5050);
    poll(1'b1, 1'b1, 8'd10, 32'd5060);
    poll(1'b1, 1'b1, 8'd72, 32'd5070);
    poll(1'b1, 1'b1, 8'd200, 32'd5080);
    poll(1'b1, 1'b1, 8'd72, 32'd5090);
    poll(1'b0, 1'b0, 8'd0, 32'd5100);
    settle();

    run_phase(160);
    settle();
    set_config(1'b1, 0, 255, 128, 64, 255, 128);
    run_phase(160);
    settle();
    set_config(1'b1, 255, 0, 1, 254, 0, 0);
    run_phase(140);
    settle();
    set_config(1'b1, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(2, 40), $urandom_range(0, 10));
    run_phase(160);
    settle();
    cfg_write(REG_NOTIFY, 32'hFFFF_FFFE);
    cfg_write(REG_UNUSED, $urandom);
    run_phase(80);
    settle();
    set_config(1'b1, 140, 220, 35, 90, 10, 1);
    run_phase(160);
    settle();

    if (event_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: touch_wheel_gesture_tracker.f
+incdir+hw/rtl
hw/rtl/twgt_pkg.sv
hw/rtl/twgt_ring_ram.sv
hw/rtl/twgt_result_fifo.sv
hw/rtl/twgt_cfg_regs.sv
hw/rtl/twgt_core.sv
hw/rtl/touch_wheel_gesture_tracker.sv
bench/gesture_event_check.sv
bench/tb_top.sv
